### rtl/mtsd_pkg.sv
package mtsd_pkg;

  localparam int unsigned PacketBytes = 188;
  localparam logic [7:0] SyncByte = 8'h47;
  localparam logic [7:0] TidPat = 8'h00;
  localparam logic [7:0] TidPmt = 8'h02;

  typedef enum logic [4:0] {
    PH_IDLE, PH_HDR1, PH_HDR2, PH_HDR3, PH_AF_LEN, PH_AF_SKIP, PH_POINTER,
    PH_TABLE_ID, PH_LEN_HI, PH_LEN_LO, PH_SEC_FIXED, PH_PROG_SKIP,
    PH_PAT_ENTRY, PH_PMT_ENTRY, PH_ES_SKIP, PH_PES_PREFIX, PH_PES_FLAGS,
    PH_PES_OPT, PH_PAYLOAD
  } phase_e;

  typedef enum logic [1:0] {
    PK_NONE, PK_TABLE, PK_PES
  } pay_kind_e;

  typedef struct packed {
    logic        sync_ok;
    logic        pkt_end;
    logic        usf;
    logic        is_pat;
    logic        sec_empty;
    logic        sec_one;
    logic        fc3;
    logic [1:0]  fc_b;
    logic        b_zero;
    logic        tid_ok;
    logic        fit4;
    logic        fit5;
    logic        info_fits;
    logic        info_zero;
    logic        prefix_ok;
    logic        sid_special;
    logic [11:0] skip;
    pay_kind_e   pay;
  } status_t;

  typedef struct packed {
    logic   step;
    logic   pstart;
    logic   live;
    phase_e phase;
    logic   bp;
    logic   entry;
    logic   pes_go;
    logic   emit;
  } cmd_t;

endpackage

### rtl/mtsd_ctrl.sv
module mtsd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             pstart_i,
  input  mtsd_pkg::status_t st_i,
  output mtsd_pkg::cmd_t    cmd_o
);
  import mtsd_pkg::*;

  phase_e phase_q, phase_d, bp_tgt, af_tgt;
  logic live;

  assign live = step_i && !pstart_i && (phase_q != PH_IDLE) && !st_i.pkt_end;

  always_comb begin
    case (st_i.pay)
      PK_TABLE: bp_tgt = st_i.usf ? PH_POINTER : PH_TABLE_ID;
      PK_PES:   bp_tgt = st_i.usf ? PH_PES_PREFIX : PH_PAYLOAD;
      default:  bp_tgt = PH_IDLE;
    endcase
    af_tgt = st_i.fc3 ? bp_tgt : PH_IDLE;
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (step_i && pstart_i) begin
      phase_d = st_i.sync_ok ? PH_HDR1 : PH_IDLE;
    end else if (step_i && phase_q != PH_IDLE && st_i.pkt_end) begin
      phase_d = PH_IDLE;
    end else if (live) begin
      unique case (phase_q)
        PH_HDR1: phase_d = PH_HDR2;
        PH_HDR2: phase_d = PH_HDR3;
        PH_HDR3: begin
          if (st_i.fc_b[1]) phase_d = PH_AF_LEN;
          else if (st_i.fc_b[0]) phase_d = bp_tgt;
          else phase_d = PH_IDLE;
        end
        PH_AF_LEN: phase_d = st_i.b_zero ? af_tgt : PH_AF_SKIP;
        PH_AF_SKIP: if (st_i.skip == 12'd1) phase_d = af_tgt;
        PH_POINTER: phase_d = PH_TABLE_ID;
        PH_TABLE_ID: phase_d = st_i.tid_ok ? PH_LEN_HI : PH_IDLE;
        PH_LEN_HI: phase_d = PH_LEN_LO;
        PH_LEN_LO: phase_d = PH_SEC_FIXED;
        PH_SEC_FIXED: begin
          if (st_i.sec_empty) phase_d = PH_IDLE;
          else if (st_i.is_pat && st_i.skip == 12'd4)
            phase_d = st_i.fit4 ? PH_PAT_ENTRY : PH_IDLE;
          else if (!st_i.is_pat && st_i.skip == 12'd8) begin
            if (st_i.info_zero) phase_d = st_i.fit5 ? PH_PMT_ENTRY : PH_IDLE;
            else phase_d = PH_PROG_SKIP;
          end
        end
        PH_PROG_SKIP, PH_ES_SKIP: begin
          if (st_i.sec_empty) phase_d = PH_IDLE;
          else if (st_i.skip == 12'd1) phase_d = st_i.fit5 ? PH_PMT_ENTRY : PH_IDLE;
        end
        PH_PAT_ENTRY: begin
          if (st_i.sec_empty) phase_d = PH_IDLE;
          else if (st_i.skip == 12'd3) phase_d = st_i.fit4 ? PH_PAT_ENTRY : PH_IDLE;
        end
        PH_PMT_ENTRY: begin
          if (st_i.sec_empty) phase_d = PH_IDLE;
          else if (st_i.skip == 12'd4) begin
            if (!st_i.info_fits) phase_d = PH_IDLE;
            else if (st_i.info_zero) phase_d = st_i.fit5 ? PH_PMT_ENTRY : PH_IDLE;
            else phase_d = PH_ES_SKIP;
          end
        end
        PH_PES_PREFIX: begin
          if (st_i.skip == 12'd2 && !st_i.prefix_ok) phase_d = PH_IDLE;
          else if (st_i.skip == 12'd5)
            phase_d = st_i.sid_special ? PH_PAYLOAD : PH_PES_FLAGS;
        end
        PH_PES_FLAGS: if (st_i.skip == 12'd2) phase_d = st_i.b_zero ? PH_PAYLOAD : PH_PES_OPT;
        PH_PES_OPT: if (st_i.sec_one) phase_d = PH_PAYLOAD;
        PH_PAYLOAD: phase_d = PH_PAYLOAD;
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  // commands
  always_comb begin
    cmd_o.step   = step_i;
    cmd_o.pstart = step_i && pstart_i;
    cmd_o.live   = live;
    cmd_o.phase  = phase_q;
    cmd_o.emit   = live && phase_q == PH_PAYLOAD;
    cmd_o.bp     = live && ((phase_q == PH_HDR3 && st_i.fc_b == 2'd1) ||
                   (phase_q == PH_AF_LEN && st_i.b_zero && st_i.fc3) ||
                   (phase_q == PH_AF_SKIP && st_i.skip == 12'd1 && st_i.fc3));
    cmd_o.entry = live && (phase_d == PH_PAT_ENTRY || phase_d == PH_PMT_ENTRY) &&
                  !st_i.sec_empty &&
                  ((phase_q == PH_SEC_FIXED) || (phase_q == PH_PROG_SKIP) ||
                   (phase_q == PH_ES_SKIP) ||
                   (phase_q == PH_PAT_ENTRY && st_i.skip == 12'd3) ||
                   (phase_q == PH_PMT_ENTRY && st_i.skip == 12'd4));
    cmd_o.pes_go = live && phase_d == PH_PAYLOAD && phase_q != PH_PAYLOAD &&
                   (phase_q == PH_PES_PREFIX || phase_q == PH_PES_FLAGS ||
                    phase_q == PH_PES_OPT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) phase_q <= PH_IDLE;
    else phase_q <= phase_d;
  end

endmodule

### rtl/mtsd_dpath.sv
module mtsd_dpath #(
  parameter int unsigned MAX_PROGRAMS = 16,
  parameter int unsigned MAX_STREAMS  = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        data_byte_i,
  input  mtsd_pkg::cmd_t    cmd_i,
  output mtsd_pkg::status_t st_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        payload_byte_o,
  output logic [12:0]       stream_pid_o,
  output logic [7:0]        stream_kind_o,
  output logic              unit_start_o,
  output logic [32:0]       present_time_o,
  output logic [32:0]       decode_time_o
);
  import mtsd_pkg::*;

  function automatic logic [32:0] stamp33(input logic [39:0] f);
    stamp33 = {f[35:33], f[31:24], f[23:17], f[15:8], f[7:1]};
  endfunction

  logic [7:0]  b;
  logic [7:0]  idx_q, idx_d;
  logic [12:0] pid_q, pid_d;
  logic        usf_q, usf_d;
  logic [1:0]  fc_q, fc_d;
  logic [11:0] skip_q, skip_d;
  logic [11:0] rem_q, rem_d, rem_dec;
  logic [1:0]  flg_q, flg_d;
  logic [39:0] fa_q, fa_d, fa_sh;
  logic [32:0] pts_q, pts_d, dts_q, dts_d;
  logic [7:0]  kind_q, kind_d;
  logic [11:0] info;
  logic        is_pat, map_hit, strm_hit;
  logic [7:0]  hit_kind, sid;

  logic        map_vld_q [MAX_PROGRAMS];
  logic [12:0] map_pid_q [MAX_PROGRAMS];
  logic        str_vld_q [MAX_STREAMS];
  logic [12:0] str_pid_q [MAX_STREAMS];
  logic [7:0]  str_kind_q [MAX_STREAMS];

  logic        add_prog, add_strm, clr_map, clr_str;
  logic [12:0] new_pid;
  logic [7:0]  new_kind;
  logic        prog_dup, prog_free_found, str_match, str_free_found;
  logic [MAX_PROGRAMS-1:0] prog_wr;
  logic [MAX_STREAMS-1:0]  str_wr, str_eq;

  logic        ov_q;
  logic [7:0]  ob_q;
  logic [12:0] opid_q;
  logic [7:0]  okind_q;
  logic        ous_q;
  logic [32:0] opts_q, odts_q;

  assign b       = data_byte_i;
  assign is_pat  = (pid_q == 13'd0);
  assign fa_sh   = {fa_q[31:0], b};
  assign rem_dec = rem_q - 12'd1;
  assign info    = {fa_q[3:0], b};
  assign sid     = fa_q[15:8];

  always_comb begin
    map_hit = 1'b0;
    for (int i = 0; i < MAX_PROGRAMS; i++)
      if (map_vld_q[i] && map_pid_q[i] == pid_q) map_hit = 1'b1;
    strm_hit = 1'b0;
    hit_kind = '0;
    for (int i = 0; i < MAX_STREAMS; i++)
      if (str_vld_q[i] && str_pid_q[i] == pid_q) begin
        strm_hit = 1'b1;
        hit_kind = hit_kind | str_kind_q[i];
      end
  end

  always_comb begin
    st_o.sync_ok   = (b == SyncByte);
    st_o.pkt_end   = (idx_q >= 8'(PacketBytes - 1));
    st_o.usf       = usf_q;
    st_o.is_pat    = is_pat;
    st_o.sec_empty = (rem_q == 12'd0);
    st_o.sec_one   = (rem_q == 12'd1);
    st_o.fc3       = (fc_q == 2'd3);
    st_o.fc_b      = b[5:4];
    st_o.b_zero    = (b == 8'd0);
    st_o.tid_ok    = (b == (is_pat ? TidPat : TidPmt));
    st_o.fit4      = (rem_dec >= 12'd8);
    st_o.fit5      = (rem_dec >= 12'd9);
    st_o.info_fits = ({1'b0, info} + 13'd4) <= {1'b0, rem_dec};
    st_o.info_zero = (info == 12'd0);
    st_o.prefix_ok = (fa_sh[23:0] == 24'd1);
    st_o.sid_special = (sid == 8'hBC) || (sid == 8'hBE) || (sid == 8'hBF) ||
                       (sid == 8'hF0) || (sid == 8'hF1) || (sid == 8'hF2) ||
                       (sid == 8'hF8) || (sid == 8'hFF);
    st_o.skip      = skip_q;
    if (pid_q == 13'd0) st_o.pay = PK_TABLE;
    else if (pid_q == 13'd1 || pid_q == 13'd2 || pid_q == 13'd3 || pid_q == 13'h11)
      st_o.pay = PK_NONE;
    else if (map_hit) st_o.pay = PK_TABLE;
    else if (pid_q == 13'h42 || pid_q == 13'h1FFF) st_o.pay = PK_NONE;
    else if (strm_hit) st_o.pay = PK_PES;
    else st_o.pay = PK_NONE;
  end

  always_comb begin
    idx_d = idx_q; pid_d = pid_q; usf_d = usf_q; fc_d = fc_q; skip_d = skip_q;
    rem_d = rem_q; flg_d = flg_q; fa_d = fa_q; pts_d = pts_q; dts_d = dts_q;
    kind_d = kind_q;
    add_prog = 1'b0; add_strm = 1'b0; clr_map = 1'b0; clr_str = 1'b0;
    new_pid = {fa_q[4:0], b};
    new_kind = fa_q[31:24];
    if (cmd_i.step && cmd_i.phase == PH_IDLE) begin
      // nothing moves while idle
    end
    if (cmd_i.step && cmd_i.phase != PH_IDLE) idx_d = idx_q + 8'd1;
    if (cmd_i.live) begin
      case (cmd_i.phase)
        PH_HDR1: begin
          usf_d = b[6];
          pid_d = {b[4:0], 8'd0};
        end
        PH_HDR2: pid_d = {pid_q[12:8], b};
        PH_HDR3: fc_d = b[5:4];
        PH_AF_LEN: skip_d = {4'd0, b};
        PH_AF_SKIP: skip_d = skip_q - 12'd1;
        PH_LEN_HI: rem_d = {b[3:0], 8'd0};
        PH_LEN_LO: begin
          rem_d = {rem_q[11:8], b};
          skip_d = '0;
          fa_d = '0;
          clr_map = is_pat;
          clr_str = !is_pat;
        end
        PH_SEC_FIXED: if (rem_q != 12'd0) begin
          rem_d = rem_dec;
          fa_d = fa_sh;
          skip_d = skip_q + 12'd1;
          if (!is_pat && skip_q == 12'd8) skip_d = info;
        end
        PH_PROG_SKIP, PH_ES_SKIP: if (rem_q != 12'd0) begin
          rem_d = rem_dec;
          skip_d = skip_q - 12'd1;
        end
        PH_PAT_ENTRY: if (rem_q != 12'd0) begin
          rem_d = rem_dec;
          fa_d = fa_sh;
          skip_d = skip_q + 12'd1;
          if (skip_q == 12'd3 && fa_q[23:8] != 16'd0) add_prog = 1'b1;
        end
        PH_PMT_ENTRY: if (rem_q != 12'd0) begin
          rem_d = rem_dec;
          fa_d = fa_sh;
          skip_d = skip_q + 12'd1;
          if (skip_q == 12'd4 && st_o.info_fits) begin
            add_strm = 1'b1;
            new_pid = fa_q[20:8];
            skip_d = info;
          end
        end
        PH_PES_PREFIX: begin
          fa_d = fa_sh;
          skip_d = skip_q + 12'd1;
          if (skip_q == 12'd5 && !st_o.sid_special) skip_d = '0;
        end
        PH_PES_FLAGS: begin
          skip_d = skip_q + 12'd1;
          if (skip_q == 12'd1) flg_d = b[7:6];
          else if (skip_q == 12'd2) begin
            rem_d = {4'd0, b};
            skip_d = '0;
            fa_d = '0;
          end
        end
        PH_PES_OPT: begin
          fa_d = fa_sh;
          skip_d = skip_q + 12'd1;
          if (skip_q == 12'd4 && flg_q[1]) pts_d = stamp33(fa_sh);
          if (skip_q == 12'd9 && flg_q == 2'd3) dts_d = stamp33(fa_sh);
          rem_d = rem_dec;
        end
        PH_PAYLOAD: usf_d = 1'b0;
        default: ;
      endcase
      if (cmd_i.entry) begin
        skip_d = '0;
        fa_d = '0;
      end
      if (cmd_i.bp && st_o.pay == PK_PES) begin
        kind_d = hit_kind;
        if (usf_q) begin
          usf_d = 1'b0; pts_d = '0; dts_d = '0; flg_d = '0; skip_d = '0; fa_d = '0;
        end
      end
      if (cmd_i.pes_go) usf_d = 1'b1;
    end
    if (cmd_i.step && cmd_i.phase == PH_IDLE) idx_d = idx_q;
  end

  // table insert: existing entry first, then lowest free slot
  always_comb begin
    prog_dup = 1'b0;
    prog_free_found = 1'b0;
    prog_wr = '0;
    for (int i = 0; i < MAX_PROGRAMS; i++)
      if (map_vld_q[i] && map_pid_q[i] == new_pid) prog_dup = 1'b1;
    for (int i = 0; i < MAX_PROGRAMS; i++)
      if (!map_vld_q[i] && !prog_free_found) begin
        prog_free_found = 1'b1;
        prog_wr[i] = add_prog && !prog_dup;
      end
    str_match = 1'b0;
    str_free_found = 1'b0;
    str_wr = '0;
    for (int i = 0; i < MAX_STREAMS; i++) begin
      str_eq[i] = str_vld_q[i] && str_pid_q[i] == new_pid;
      if (str_eq[i]) str_match = 1'b1;
    end
    for (int i = 0; i < MAX_STREAMS; i++)
      if (!str_vld_q[i] && !str_free_found) begin
        str_free_found = 1'b1;
        str_wr[i] = add_strm && !str_match;
      end
    if (str_match) str_wr = add_strm ? str_eq : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_PROGRAMS; i++) map_vld_q[i] <= 1'b0;
      for (int i = 0; i < MAX_STREAMS; i++) str_vld_q[i] <= 1'b0;
    end else begin
      for (int i = 0; i < MAX_PROGRAMS; i++)
        if (clr_map) map_vld_q[i] <= 1'b0;
        else if (prog_wr[i]) map_vld_q[i] <= 1'b1;
      for (int i = 0; i < MAX_STREAMS; i++)
        if (clr_str) str_vld_q[i] <= 1'b0;
        else if (str_wr[i]) str_vld_q[i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_PROGRAMS; i++)
      if (prog_wr[i]) map_pid_q[i] <= new_pid;
    for (int i = 0; i < MAX_STREAMS; i++)
      if (str_wr[i]) begin
        str_pid_q[i]  <= new_pid;
        str_kind_q[i] <= new_kind;
      end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0; pid_q <= '0; usf_q <= 1'b0; fc_q <= '0; skip_q <= '0;
      rem_q <= '0; flg_q <= '0; fa_q <= '0; pts_q <= '0; dts_q <= '0;
      kind_q <= '0;
    end else if (cmd_i.step) begin
      if (cmd_i.pstart) begin
        // packet start beat
        idx_q <= '0;
        usf_q <= 1'b0;
      end else begin
        idx_q <= idx_d; pid_q <= pid_d; usf_q <= usf_d; fc_q <= fc_d;
        skip_q <= skip_d; rem_q <= rem_d; flg_q <= flg_d; fa_q <= fa_d;
        pts_q <= pts_d; dts_q <= dts_d; kind_q <= kind_d;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (cmd_i.emit) ov_q <= 1'b1;
    else if (out_ready_i) ov_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      ob_q    <= b;
      opid_q  <= pid_q;
      okind_q <= kind_q;
      ous_q   <= usf_q;
      opts_q  <= pts_q;
      odts_q  <= (dts_q != 33'd0) ? dts_q : pts_q;
    end
  end

  assign out_valid_o    = ov_q;
  assign payload_byte_o = ob_q;
  assign stream_pid_o   = opid_q;
  assign stream_kind_o  = okind_q;
  assign unit_start_o   = ous_q;
  assign present_time_o = opts_q;
  assign decode_time_o  = odts_q;

endmodule

### rtl/mpeg_ts_demultiplexer.sv
// transport stream demux: one byte beat per cycle unless the output stalls
// a payload beat shows up at the output in the cycle after it is accepted
// input stalls only while a finished result waits in the output register
// rst_ni asynchronous active low: parser idles until a 0x47 packet start,
// PAT and PMT tables come up empty (valid bits cleared)
module mpeg_ts_demultiplexer #(
  parameter int unsigned MAX_PROGRAMS = 16,
  parameter int unsigned MAX_STREAMS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        packet_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  payload_byte_o,
  output logic [12:0] stream_pid_o,
  output logic [7:0]  stream_kind_o,
  output logic        unit_start_o,
  output logic [32:0] present_time_o,
  output logic [32:0] decode_time_o
);
  import mtsd_pkg::*;

  status_t st;
  cmd_t    cmd;
  logic    step;

  // accept whenever the result slot is free or drains this cycle
  assign in_ready_o = !out_valid_o || out_ready_i;
  assign step       = in_valid_i && in_ready_o;

  // phase sequencer
  mtsd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .pstart_i (packet_start_i),
    .st_i     (st),
    .cmd_o    (cmd)
  );

  // counters, field assembly, pid tables, result register
  mtsd_dpath #(
    .MAX_PROGRAMS (MAX_PROGRAMS),
    .MAX_STREAMS  (MAX_STREAMS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .data_byte_i    (data_byte_i),
    .cmd_i          (cmd),
    .st_o           (st),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .payload_byte_o (payload_byte_o),
    .stream_pid_o   (stream_pid_o),
    .stream_kind_o  (stream_kind_o),
    .unit_start_o   (unit_start_o),
    .present_time_o (present_time_o),
    .decode_time_o  (decode_time_o)
  );

  // a packet start beat never yields a result
  a_pstart_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && packet_start_i) |=> !out_valid_o)
    else $error("result after packet start beat");

  // empty result slot always takes input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("stall with empty result slot");

  // only payload phase emits
  a_emit_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (cmd.phase == PH_PAYLOAD && step))
    else $error("emit outside payload phase");

endmodule
